// ===== hw/rtl/crb_pkg.sv =====
// Shared types and constants for the checkerboard point residual block.
`timescale 1ns / 1ps

package crb_pkg;

   // field widths
   localparam int PT_W       = 32;
   localparam int COS_W      = 18;
   localparam int SHIFT_W    = 32;
   localparam int INV_W      = 24;
   localparam int CELLS_W    = 7;
   localparam int MODE_W     = 2;
   localparam int RES_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // internal datapath widths
   localparam int ROT_P_W  = COS_W + PT_W;   // one rotation product
   localparam int ROT_S_W  = ROT_P_W + 1;    // sum of two rotation products
   localparam int RW       = 44;             // rotated and shifted coordinate
   localparam int RL_W     = 22;             // low slice of the coordinate for scaling
   localparam int PROD_W   = 68;             // full scaled product
   localparam int CW       = 42;             // cell coordinate
   localparam int SAT_LOG  = 40;             // cell coordinate clamps at 2^40
   localparam int GUARD_LOG = 62;            // products at or above 2^62 clamp directly

   // queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   // mode bits
   localparam int MODE_TL_WHITE = 0;
   localparam int MODE_PENALIZE = 1;

   // reset values
   localparam logic [INV_W-1:0]   INV_RESET  = INV_W'(436907);
   localparam logic [CELLS_W-1:0] COLS_RESET = CELLS_W'(7);
   localparam logic [CELLS_W-1:0] ROWS_RESET = CELLS_W'(8);
   localparam logic [MODE_W-1:0]  MODE_RESET = MODE_W'(2);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROT_COS  = 3'd0,
      CSR_ROT_SIN  = 3'd1,
      CSR_SHIFT_Y  = 3'd2,
      CSR_SHIFT_Z  = 3'd3,
      CSR_INV_CELL = 3'd4,
      CSR_COLS     = 3'd5,
      CSR_ROWS     = 3'd6,
      CSR_MODE     = 3'd7
   } csr_idx_type;

   typedef enum logic [1:0] {
      REGION_MATCH    = 2'd0,
      REGION_MISMATCH = 2'd1,
      REGION_OFF_PEN  = 2'd2,
      REGION_OFF_IGN  = 2'd3
   } region_type;

   typedef struct packed {
      logic [COS_W-1:0]   rot_cos;
      logic [COS_W-1:0]   rot_sin;
      logic [SHIFT_W-1:0] shift_y;
      logic [SHIFT_W-1:0] shift_z;
      logic [INV_W-1:0]   inv_cell_size;
      logic [CELLS_W-1:0] board_cols;
      logic [CELLS_W-1:0] board_rows;
      logic [MODE_W-1:0]  mode_bits;
   } cfg_type;

   // board-frame point handed from front to back
   typedef struct packed {
      logic [RW-1:0] ry;
      logic [RW-1:0] rz;
      logic          white;
   } xfm_type;

endpackage

// ===== hw/rtl/crb_if.sv =====
// Channel interfaces: point request, residual response, register write.
`timescale 1ns / 1ps

interface crb_req_if;
   import crb_pkg::*;
   logic                   valid;
   logic                   ready;
   logic signed [PT_W-1:0] point_y;
   logic signed [PT_W-1:0] point_z;
   logic                   point_white;
   modport source (output valid, point_y, point_z, point_white, input ready);
   modport sink   (input valid, point_y, point_z, point_white, output ready);
endinterface

interface crb_rsp_if;
   import crb_pkg::*;
   logic             valid;
   logic             ready;
   logic [RES_W-1:0] residual;
   logic [1:0]       region;
   modport source (output valid, residual, region, input ready);
   modport sink   (input valid, residual, region, output ready);
endinterface

interface crb_csr_if;
   import crb_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== hw/rtl/crb_front.sv =====
// Front end: accept point requests and rotate and shift them into the board frame.
`timescale 1ns / 1ps

module crb_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  crb_pkg::cfg_type              cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [crb_pkg::PT_W-1:0]      point_y,
   input  logic [crb_pkg::PT_W-1:0]      point_z,
   input  logic                          point_white,
   output logic                          out_valid,
   input  logic                          out_ready,
   output crb_pkg::xfm_type              out_data
);
   import crb_pkg::*;

   logic signed [COS_W-1:0]   cos_s, sin_s;
   logic signed [SHIFT_W-1:0] sy_s, sz_s;
   logic signed [PT_W-1:0]    y_s, z_s;
   logic rdy1, rdy2, rdy3;

   logic v1_ff, v2_ff, v3_ff;
   logic w1_ff, w2_ff, w3_ff;
   logic signed [ROT_P_W-1:0] cy_in, sz_in, sy_in, cz_in;
   logic signed [ROT_P_W-1:0] cy_ff, sz_ff, sy_ff, cz_ff;
   logic signed [ROT_S_W-1:0] sum_y_in, sum_z_in, sum_y_ff, sum_z_ff;
   logic signed [RW-1:0]      ry_in, rz_in, ry_ff, rz_ff;

   assign cos_s = cfg.rot_cos;
   assign sin_s = cfg.rot_sin;
   assign sy_s  = cfg.shift_y;
   assign sz_s  = cfg.shift_z;
   assign y_s   = point_y;
   assign z_s   = point_z;

   // each stage moves when it is empty or its successor moves
   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      cy_in    = ROT_P_W'(cos_s) * ROT_P_W'(y_s);
      sz_in    = ROT_P_W'(sin_s) * ROT_P_W'(z_s);
      sy_in    = ROT_P_W'(sin_s) * ROT_P_W'(y_s);
      cz_in    = ROT_P_W'(cos_s) * ROT_P_W'(z_s);
      sum_y_in = ROT_S_W'(cy_ff) - ROT_S_W'(sz_ff);
      sum_z_in = ROT_S_W'(sy_ff) + ROT_S_W'(cz_ff);
      ry_in    = RW'(sum_y_ff >>> FRAC_BITS) + RW'(sy_s);
      rz_in    = RW'(sum_z_ff >>> FRAC_BITS) + RW'(sz_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         cy_ff <= cy_in;
         sz_ff <= sz_in;
         sy_ff <= sy_in;
         cz_ff <= cz_in;
         w1_ff <= point_white;
      end
      if (rdy2) begin
         sum_y_ff <= sum_y_in;
         sum_z_ff <= sum_z_in;
         w2_ff    <= w1_ff;
      end
      if (rdy3) begin
         ry_ff <= ry_in;
         rz_ff <= rz_in;
         w3_ff <= w2_ff;
      end
   end

   assign out_valid      = v3_ff;
   assign out_data.ry    = ry_ff;
   assign out_data.rz    = rz_ff;
   assign out_data.white = w3_ff;

endmodule

// ===== hw/rtl/crb_queue.sv =====
// Short queue of board-frame points between front and back.
`timescale 1ns / 1ps

module crb_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  crb_pkg::xfm_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output crb_pkg::xfm_type pop_data
);
   import crb_pkg::*;

   xfm_type             mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wptr_ff, rptr_ff;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                push, pop;

   assign push_ready = count_ff != (QPTR_W + 1)'(QDEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rptr_ff];

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) wptr_ff <= wptr_ff + 1'b1;
         if (pop)  rptr_ff <= rptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_data;
   end

endmodule

// ===== hw/rtl/crb_back.sv =====
// Back end: scale to cell units, classify against the board and form the residual.
`timescale 1ns / 1ps

module crb_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  crb_pkg::cfg_type            cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  crb_pkg::xfm_type            in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [crb_pkg::RES_W-1:0]   residual,
   output crb_pkg::region_type         region
);
   import crb_pkg::*;

   localparam int PL_W = RL_W + INV_W;
   localparam int RH_W = RW - RL_W;
   localparam int PH_W = RH_W + INV_W + 1;
   localparam int CD_W = FRAC_BITS + 1;
   localparam logic signed [PROD_W-1:0] CSAT = PROD_W'(1) <<< SAT_LOG;
   localparam logic [CD_W-1:0] ONE  = CD_W'(1) << FRAC_BITS;
   localparam logic [CD_W-1:0] HALF = CD_W'(1) << (FRAC_BITS - 1);

   logic adv;
   logic b1_v_ff, b2_v_ff, b3_v_ff, b4_v_ff, b5_v_ff, out_v_ff;
   logic w1_ff, w2_ff, w3_ff;

   logic [CELLS_W-1:0]       cells [2];
   logic signed [RW-1:0]     r [2];
   logic signed [INV_W:0]    inv_s;

   logic [PL_W-1:0]          pl_in [2], pl_ff [2];
   logic signed [PH_W-1:0]   ph_in [2], ph_ff [2];
   logic signed [PROD_W-1:0] p_in [2], p_ff [2];
   logic signed [PROD_W-1:0] q [2], sat [2];
   logic                     pos_big [2], neg_big [2];
   logic signed [CW-1:0]     c_in [2], c_ff [2];
   logic signed [CW-1:0]     wlim [2];
   logic                     on_board [2];
   logic [FRAC_BITS-1:0]     frac [2];
   logic [CD_W-1:0]          cd_in [2], cd_ff [2];
   logic [CW-1:0]            lo_in [2], lo_ff [2];
   logic signed [CW:0]       d_in [2], d_ff [2];
   logic [CW-1:0]            hi [2], edist [2];
   logic [CW-1:0]            term_in [2], term_ff [2];
   logic                     tile_white;
   region_type               region4_in, region4_ff, region5_ff, region_ff;
   logic [CW:0]              sum;
   logic [RES_W-1:0]         residual_in, residual_ff;

   // whole back pipeline advances together behind the output register
   assign adv      = !out_v_ff || out_ready;
   assign in_ready = adv;

   assign cells[0] = cfg.board_cols;
   assign cells[1] = cfg.board_rows;
   assign r[0]     = in_data.ry;
   assign r[1]     = in_data.rz;
   assign inv_s    = {1'b0, cfg.inv_cell_size};

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         // split scaling into two partial products
         pl_in[i] = PL_W'(r[i][RL_W-1:0]) * PL_W'(cfg.inv_cell_size);
         ph_in[i] = PH_W'($signed(r[i][RW-1:RL_W])) * PH_W'(inv_s);
         p_in[i]  = (PROD_W'(ph_ff[i]) <<< RL_W) + PROD_W'(pl_ff[i]);

         // clamp to +/-2^40, then center on the board
         q[i]       = p_ff[i] >>> FRAC_BITS;
         pos_big[i] = !p_ff[i][PROD_W-1] && (p_ff[i][PROD_W-2:GUARD_LOG] != '0);
         neg_big[i] = p_ff[i][PROD_W-1]
                      && !((&p_ff[i][PROD_W-2:GUARD_LOG]) && (p_ff[i][GUARD_LOG-1:0] != '0));
         if (pos_big[i] || (q[i] > CSAT)) begin
            sat[i] = CSAT;
         end else if (neg_big[i] || (q[i] < -CSAT)) begin
            sat[i] = -CSAT;
         end else begin
            sat[i] = q[i];
         end
         c_in[i] = CW'(sat[i]) + CW'({cells[i], {(FRAC_BITS - 1){1'b0}}});

         // board limits, distance to cell edge and to board edges
         wlim[i]     = CW'({cells[i], {FRAC_BITS{1'b0}}});
         on_board[i] = (c_ff[i] > 0) && (c_ff[i] < wlim[i]);
         frac[i]     = c_ff[i][FRAC_BITS-1:0];
         cd_in[i]    = (CD_W'(frac[i]) > HALF) ? ONE - CD_W'(frac[i]) : CD_W'(frac[i]);
         lo_in[i]    = c_ff[i][CW-1] ? CW'(-c_ff[i]) : CW'(c_ff[i]);
         d_in[i]     = (CW + 1)'(c_ff[i]) - (CW + 1)'(wlim[i]);

         hi[i]    = d_ff[i][CW] ? CW'(-d_ff[i]) : CW'(d_ff[i]);
         edist[i] = (lo_ff[i] < hi[i]) ? lo_ff[i] : hi[i];
         case (region4_ff)
            REGION_MISMATCH: term_in[i] = CW'(cd_ff[i]);
            REGION_OFF_PEN:  term_in[i] = edist[i];
            default:         term_in[i] = '0;
         endcase
      end
   end

   always_comb begin
      tile_white = cfg.mode_bits[MODE_TL_WHITE] ^ c_ff[0][FRAC_BITS] ^ c_ff[1][FRAC_BITS];
      if (on_board[0] && on_board[1]) begin
         region4_in = (tile_white == w3_ff) ? REGION_MATCH : REGION_MISMATCH;
      end else if (cfg.mode_bits[MODE_PENALIZE]) begin
         region4_in = REGION_OFF_PEN;
      end else begin
         region4_in = REGION_OFF_IGN;
      end
      sum         = (CW + 1)'(term_ff[0]) + (CW + 1)'(term_ff[1]);
      residual_in = (sum[CW:RES_W] != '0) ? '1 : sum[RES_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff  <= 1'b0;
         b2_v_ff  <= 1'b0;
         b3_v_ff  <= 1'b0;
         b4_v_ff  <= 1'b0;
         b5_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         b1_v_ff  <= in_valid;
         b2_v_ff  <= b1_v_ff;
         b3_v_ff  <= b2_v_ff;
         b4_v_ff  <= b3_v_ff;
         b5_v_ff  <= b4_v_ff;
         out_v_ff <= b5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pl_ff       <= pl_in;
         ph_ff       <= ph_in;
         w1_ff       <= in_data.white;
         p_ff        <= p_in;
         w2_ff       <= w1_ff;
         c_ff        <= c_in;
         w3_ff       <= w2_ff;
         cd_ff       <= cd_in;
         lo_ff       <= lo_in;
         d_ff        <= d_in;
         region4_ff  <= region4_in;
         term_ff     <= term_in;
         region5_ff  <= region4_ff;
         residual_ff <= residual_in;
         region_ff   <= region5_ff;
      end
   end

   assign out_valid = out_v_ff;
   assign residual  = residual_ff;
   assign region    = region_ff;

endmodule

// ===== hw/rtl/checkerboard_point_residual.sv =====
// Top level of the checkerboard point residual block.
`timescale 1ns / 1ps
//
//   channel   dir   handshake      payload
//   req_ch    in    valid/ready    point_y[31:0], point_z[31:0], point_white
//   rsp_ch    out   valid/ready    residual[31:0], region[1:0]
//   csr_ch    in    valid/ready    index[2:0], wdata[31:0]
//
// Throughput is one request per clock while rsp_ch is not stalled; a response reaches rsp_ch
// through three front stages, the queue and six back stages ending in the output
// register. The per-point scaling multiply is split into two partial products over
// two back stages.
// Synchronous active-high reset clears all valid state and loads the register
// defaults; csr_ch is always ready. A stalled rsp_ch freezes the back end, the queue
// soaks up what the front end still carries, and req_ch drops ready only once
// the queue and front stages are full.

module checkerboard_point_residual #(
   parameter int FRAC_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   crb_req_if.sink   req_ch,
   crb_rsp_if.source rsp_ch,
   crb_csr_if.sink   csr_ch
);
   import crb_pkg::*;

   cfg_type    cfg_ff;
   xfm_type    front_data, back_data;
   logic       front_valid, front_ready;
   logic       back_valid, back_ready;
   region_type region;

   // register file: writes land whenever offered
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rot_cos       <= COS_W'(1) << FRAC_BITS;
         cfg_ff.rot_sin       <= '0;
         cfg_ff.shift_y       <= '0;
         cfg_ff.shift_z       <= '0;
         cfg_ff.inv_cell_size <= INV_RESET;
         cfg_ff.board_cols    <= COLS_RESET;
         cfg_ff.board_rows    <= ROWS_RESET;
         cfg_ff.mode_bits     <= MODE_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_idx_type'(csr_ch.index))
            CSR_ROT_COS:  cfg_ff.rot_cos       <= csr_ch.wdata[COS_W-1:0];
            CSR_ROT_SIN:  cfg_ff.rot_sin       <= csr_ch.wdata[COS_W-1:0];
            CSR_SHIFT_Y:  cfg_ff.shift_y       <= csr_ch.wdata[SHIFT_W-1:0];
            CSR_SHIFT_Z:  cfg_ff.shift_z       <= csr_ch.wdata[SHIFT_W-1:0];
            CSR_INV_CELL: cfg_ff.inv_cell_size <= csr_ch.wdata[INV_W-1:0];
            CSR_COLS:     cfg_ff.board_cols    <= csr_ch.wdata[CELLS_W-1:0];
            CSR_ROWS:     cfg_ff.board_rows    <= csr_ch.wdata[CELLS_W-1:0];
            CSR_MODE:     cfg_ff.mode_bits     <= csr_ch.wdata[MODE_W-1:0];
            default:      cfg_ff               <= cfg_ff;
         endcase
      end
   end

   // front: rotate and shift into the board frame
   crb_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_ch.valid),
      .in_ready    (req_ch.ready),
      .point_y     (req_ch.point_y),
      .point_z     (req_ch.point_z),
      .point_white (req_ch.point_white),
      .out_valid   (front_valid),
      .out_ready   (front_ready),
      .out_data    (front_data)
   );

   // hold board-frame points while the back end stalls
   crb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_data),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_data)
   );

   // back: scale, classify, measure and saturate
   crb_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (back_valid),
      .in_ready  (back_ready),
      .in_data   (back_data),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .residual  (rsp_ch.residual),
      .region    (region)
   );

   assign rsp_ch.region = region;

endmodule
